// ===== hw/rtl/vts_pkg.sv =====
// Shared types, constants and tables of the VCA taper and soft clip unit.
package vts_pkg;

  // Sample and control formats
  localparam int SAMPLE_BITS = 16;
  localparam int CTRL_W      = 16;
  localparam int CTRL_FRAC   = 14;
  localparam logic [CTRL_W-1:0] CTRL_ONE = CTRL_W'(1) << CTRL_FRAC;

  // Configuration registers, unsigned Q4.12
  localparam int CFG_W    = 16;
  localparam int CFG_FRAC = 12;
  localparam logic [CFG_W-1:0] TAPER_EXP_RST  = CFG_W'(1) << CFG_FRAC;
  localparam logic [CFG_W-1:0] DRIVE_GAIN_RST = CFG_W'(1) << CFG_FRAC;

  // APB port
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_SEL_BIT = 2;

  typedef enum logic {
    REG_TAPER_EXP  = 1'b0,
    REG_DRIVE_GAIN = 1'b1
  } reg_idx_e;

  // Internal fixed point widths
  localparam int Q30_FRAC = 30;
  localparam int Q30_W    = Q30_FRAC + 1;   // holds 0 .. 2^30
  localparam int FRAC_W   = 16;             // Q16 fraction of log2 values
  localparam int W_W      = 24;             // exp2 argument, Q16
  localparam int LOG2_W   = 20;             // -log2 of control, Q16
  localparam int MANT_W   = 31;             // log mantissa, Q30 in [1,2)
  localparam int ARG_W    = 30;             // tanh argument, Q24
  localparam int EXP_K_MAX   = 30;
  localparam int LOG2E_SHIFT = 37;

  localparam logic [Q30_W-1:0] ONE_Q30   = Q30_W'(1) << Q30_FRAC;
  localparam logic [Q30_W-1:0] ROUND_Q30 = Q30_W'(1) << (Q30_FRAC - 1);
  localparam logic [Q30_W-1:0] LOG2E_Q30 = 31'd1549082005;

  // Pipeline latencies, accept to strobe
  localparam int EXP_LAT   = FRAC_W + 2;
  localparam int TAPER_LAT = FRAC_W + 4 + EXP_LAT;
  localparam int TANH_Q_W  = Q30_W;
  localparam int PIPE_LAT  = 1 + TAPER_LAT + 3 + EXP_LAT + (TANH_Q_W + 1) + 1
                             + (SAMPLE_BITS + 2) + 1;

  // Transfer payloads
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic signed [CTRL_W-1:0]      control_level;
    logic                          last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          last_out;
  } out_item_t;

  // Factors 2^(-2^-(i+1)) in Q30 for entry i, repeated floor square roots of one half
  localparam int ROOT_W = 30;
  typedef logic [FRAC_W-1:0][ROOT_W-1:0] root_tbl_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic root_tbl_t calc_roots();
    root_tbl_t   tbl;
    logic [63:0] s;
    s = 64'(ONE_Q30 >> 1);
    for (int i = 0; i < FRAC_W; i++) begin
      s = isqrt64(s << Q30_FRAC);
      tbl[i] = s[ROOT_W-1:0];
    end
    return tbl;
  endfunction

  localparam root_tbl_t EXP_ROOTS = calc_roots();

endpackage

// ===== hw/rtl/vts_exp2.sv =====
// Pipelined 2^-w in Q30 for a Q16 argument, one fraction bit per stage.
module vts_exp2 import vts_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [W_W-1:0]    w_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q30_W-1:0]  res_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int NST = FRAC_W;
  localparam int K_W = W_W - FRAC_W;
  localparam int P_W = 2 * Q30_W;

  logic [NST:0]        vld_q;
  logic [Q30_W-1:0]    r_q    [NST+1];
  logic [FRAC_W-1:0]   f_q    [NST+1];
  logic [K_W-1:0]      k_q    [NST+1];
  logic [SIDE_W-1:0]   side_q [NST+1];
  logic [Q30_W-1:0]    r_nx   [NST];
  logic                vld_out_q;
  logic [Q30_W-1:0]    res_q;
  logic [Q30_W-1:0]    res_d;
  logic [SIDE_W-1:0]   side_out_q;

  // one conditional multiply by a root factor per stage, MSB of fraction first
  for (genvar j = 0; j < NST; j++) begin : g_stage
    logic [P_W-1:0] prod;
    assign prod    = P_W'(r_q[j]) * P_W'(EXP_ROOTS[j]);
    assign r_nx[j] = f_q[j][FRAC_W-1-j] ? prod[Q30_FRAC +: Q30_W] : r_q[j];
  end

  // integer part: final shift, or zero when out of range
  assign res_d = (k_q[NST] > K_W'(EXP_K_MAX)) ? '0 : (r_q[NST] >> k_q[NST]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[NST-1:0], valid_i};
      vld_out_q <= vld_q[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    r_q[0]    <= ONE_Q30;
    f_q[0]    <= w_i[FRAC_W-1:0];
    k_q[0]    <= w_i[W_W-1:FRAC_W];
    side_q[0] <= side_i;
    for (int j = 0; j < NST; j++) begin
      r_q[j+1]    <= r_nx[j];
      f_q[j+1]    <= f_q[j];
      k_q[j+1]    <= k_q[j];
      side_q[j+1] <= side_q[j];
    end
    res_q      <= res_d;
    side_out_q <= side_q[NST];
  end

  assign valid_o = vld_out_q;
  assign res_o   = res_q;
  assign side_o  = side_out_q;

endmodule

// ===== hw/rtl/vts_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module vts_div import vts_pkg::*; #(
  parameter int Q_W    = 8,
  parameter int DEN_W  = 8,
  parameter int SIDE_W = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [Q_W+DEN_W-1:0]   num_i,
  input  logic [DEN_W-1:0]       den_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   valid_o,
  output logic [Q_W-1:0]         quo_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic [Q_W:0]        vld_q;
  logic [DEN_W-1:0]    rem_q  [Q_W+1];
  logic [DEN_W-1:0]    den_q  [Q_W+1];
  logic [Q_W-1:0]      low_q  [Q_W+1];
  logic [Q_W-1:0]      quo_q  [Q_W+1];
  logic [SIDE_W-1:0]   side_q [Q_W+1];
  logic [DEN_W-1:0]    rem_nx [Q_W];
  logic                qb_nx  [Q_W];

  // shift in the next numerator bit, subtract when it fits
  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;
    assign trial     = {rem_q[j], low_q[j][Q_W-1]};
    assign diff      = trial - {1'b0, den_q[j]};
    assign ge        = (trial >= {1'b0, den_q[j]});
    assign rem_nx[j] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    assign qb_nx[j]  = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Q_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num_i[Q_W +: DEN_W];
    low_q[0]  <= num_i[Q_W-1:0];
    quo_q[0]  <= '0;
    den_q[0]  <= den_i;
    side_q[0] <= side_i;
    for (int j = 0; j < Q_W; j++) begin
      rem_q[j+1]  <= rem_nx[j];
      low_q[j+1]  <= low_q[j] << 1;
      quo_q[j+1]  <= (quo_q[j] << 1) | Q_W'(qb_nx[j]);
      den_q[j+1]  <= den_q[j];
      side_q[j+1] <= side_q[j];
    end
  end

  assign valid_o = vld_q[Q_W];
  assign quo_o   = quo_q[Q_W];
  assign side_o  = side_q[Q_W];

endmodule

// ===== hw/rtl/vts_taper.sv =====
// Control taper: clamp, -log2 by repeated squaring, scale by exponent, 2^-t.
module vts_taper import vts_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [CTRL_W-1:0] ctrl_i,
  input  logic [SIDE_W-1:0] side_i,
  input  logic [CFG_W-1:0]  exponent_i,
  output logic              valid_o,
  output logic [Q30_W-1:0]  taper_o,
  output logic [SIDE_W-1:0] side_o
);

  typedef enum logic [1:0] {
    TC_LOW,
    TC_FULL,
    TC_CURVE
  } taper_cls_e;

  localparam int NSQ   = FRAC_W;
  localparam int P_W   = $clog2(CTRL_FRAC);
  localparam int SH_W  = $clog2(MANT_W);
  localparam int SQ_W  = 2 * MANT_W;
  localparam int TP_W  = LOG2_W + CFG_W;
  localparam int XS_W  = SIDE_W + 2;

  taper_cls_e        cls_d;
  logic [P_W-1:0]    p_d;
  logic [SH_W-1:0]   sh_d;
  logic [MANT_W-1:0] m_d;

  logic [NSQ:0]       vld_q;
  logic [MANT_W-1:0]  m_q    [NSQ+1];
  logic [FRAC_W-1:0]  fr_q   [NSQ+1];
  logic [P_W-1:0]     p_q    [NSQ+1];
  taper_cls_e         cls_q  [NSQ+1];
  logic [SIDE_W-1:0]  side_q [NSQ+1];
  logic [MANT_W-1:0]  m_nx   [NSQ];
  logic               b_nx   [NSQ];

  logic               vld_l_q, vld_t_q;
  logic [LOG2_W-1:0]  l_q;
  logic [LOG2_W-1:0]  l_d;
  logic [W_W-1:0]     t_q;
  logic [TP_W-1:0]    t_prod;
  taper_cls_e         cls_l_q, cls_t_q;
  logic [SIDE_W-1:0]  side_l_q, side_t_q;

  logic               e_vld;
  logic [Q30_W-1:0]   e_res;
  logic [XS_W-1:0]    e_side;
  taper_cls_e         e_cls;
  logic               vld_o_q;
  logic [Q30_W-1:0]   taper_q, taper_d;
  logic [SIDE_W-1:0]  side_o_q;

  // classify the control and normalize it into a Q30 mantissa
  always_comb begin
    priority if (ctrl_i[CTRL_W-1] || ctrl_i == '0) begin
      cls_d = TC_LOW;
    end else if (ctrl_i >= CTRL_ONE) begin
      cls_d = TC_FULL;
    end else begin
      cls_d = TC_CURVE;
    end
    p_d = '0;
    for (int b = 0; b < CTRL_FRAC; b++) begin
      if (ctrl_i[b]) p_d = P_W'(b);
    end
    sh_d = SH_W'(MANT_W - 1) - SH_W'(p_d);
    m_d  = MANT_W'(ctrl_i[CTRL_FRAC-1:0]) << sh_d;
  end

  // one squaring per stage gives one fraction bit of the log
  for (genvar j = 0; j < NSQ; j++) begin : g_sq
    logic [SQ_W-1:0]   sq;
    logic [MANT_W:0]   hi;
    assign sq      = SQ_W'(m_q[j]) * SQ_W'(m_q[j]);
    assign hi      = sq[Q30_FRAC +: MANT_W+1];
    assign m_nx[j] = hi[MANT_W] ? hi[MANT_W:1] : hi[MANT_W-1:0];
    assign b_nx[j] = hi[MANT_W];
  end

  assign l_d = (LOG2_W'(CTRL_FRAC - 1) - LOG2_W'(p_q[NSQ]) + LOG2_W'(1)) << FRAC_W;
  assign t_prod = TP_W'(l_q) * TP_W'(exponent_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      vld_l_q <= 1'b0;
      vld_t_q <= 1'b0;
      vld_o_q <= 1'b0;
    end else begin
      vld_q   <= {vld_q[NSQ-1:0], valid_i};
      vld_l_q <= vld_q[NSQ];
      vld_t_q <= vld_l_q;
      vld_o_q <= e_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q[0]    <= m_d;
    fr_q[0]   <= '0;
    p_q[0]    <= p_d;
    cls_q[0]  <= cls_d;
    side_q[0] <= side_i;
    for (int j = 0; j < NSQ; j++) begin
      m_q[j+1]    <= m_nx[j];
      fr_q[j+1]   <= {fr_q[j][FRAC_W-2:0], b_nx[j]};
      p_q[j+1]    <= p_q[j];
      cls_q[j+1]  <= cls_q[j];
      side_q[j+1] <= side_q[j];
    end
    // -log2 in Q16, then scale by the exponent
    l_q      <= l_d - LOG2_W'(fr_q[NSQ]);
    cls_l_q  <= cls_q[NSQ];
    side_l_q <= side_q[NSQ];
    t_q      <= t_prod[CFG_FRAC +: W_W];
    cls_t_q  <= cls_l_q;
    side_t_q <= side_l_q;
    taper_q  <= taper_d;
    side_o_q <= e_side[SIDE_W-1:0];
  end

  vts_exp2 #(
    .SIDE_W (XS_W)
  ) u_exp2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_t_q),
    .w_i     (t_q),
    .side_i  ({cls_t_q, side_t_q}),
    .valid_o (e_vld),
    .res_o   (e_res),
    .side_o  (e_side)
  );

  // clamped ends of the control range override the curve
  assign e_cls = taper_cls_e'(e_side[XS_W-1:SIDE_W]);
  always_comb begin
    unique case (e_cls)
      TC_LOW:   taper_d = (exponent_i == '0) ? ONE_Q30 : '0;
      TC_FULL:  taper_d = ONE_Q30;
      TC_CURVE: taper_d = e_res;
      default:  taper_d = '0;
    endcase
  end

  assign valid_o = vld_o_q;
  assign taper_o = taper_q;
  assign side_o  = side_o_q;

endmodule

// ===== hw/rtl/vca_taper_soft_clip_unit.sv =====
// Top level of the VCA taper and soft clip unit: config regs, drive, tanh and output stages.
//
//   channel   signals                          transfer
//   input     start, busy, item_i              start high, busy low at a rising edge
//   result    result_strobe_o, result_o        one cycle with strobe high
//   config    psel penable pwrite paddr pwdata APB write, pready always high
//
// One item enters per cycle; busy is never raised. Each result passes through the
// input register, the log squaring chain, the two exp2 chains and the two
// bit-per-stage dividers on its way to the result register.
// Reset clears the valid bits and loads the register defaults.
// The result side cannot stall, so the pipeline never holds.
module vca_taper_soft_clip_unit import vts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  in_item_t           item_i,
  output logic               result_strobe_o,
  output out_item_t          result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int SB     = SAMPLE_BITS;
  localparam int QW     = SB + 1;
  localparam int DT_W   = CFG_W + Q30_W;
  localparam int MP_W   = Q30_W + SB;
  localparam int WP_W   = ARG_W + Q30_W;
  localparam int TDEN_W = Q30_W + 1;
  localparam int NUMF_W = QW + Q30_W;

  typedef struct packed {
    logic          last;
    logic          neg;
    logic [SB-1:0] mag;
  } tside_t;

  typedef struct packed {
    logic          neg;
    logic [SB-1:0] q0;
  } sside_t;

  typedef struct packed {
    logic          sat;
    logic          neg;
    logic [SB-1:0] q0;
    logic          last;
  } fside_t;

  // configuration registers
  logic [CFG_W-1:0] taper_exp_q, drive_q;
  logic             cfg_we;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[REG_SEL_BIT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taper_exp_q <= TAPER_EXP_RST;
      drive_q     <= DRIVE_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TAPER_EXP:  taper_exp_q <= pwdata[CFG_W-1:0];
        REG_DRIVE_GAIN: drive_q     <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TAPER_EXP:  prdata = PDATA_W'(taper_exp_q);
      REG_DRIVE_GAIN: prdata = PDATA_W'(drive_q);
      default:        prdata = '0;
    endcase
  end

  // input register and sample magnitude
  logic            vld_a_q;
  in_item_t        item_a_q;
  logic [SB-1:0]   s_a;
  tside_t          side_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_a_q <= 1'b0;
    else         vld_a_q <= start & ~busy;
  end

  always_ff @(posedge clk_i) begin
    item_a_q <= item_i;
  end

  assign s_a         = item_a_q.sample_in;
  assign side_a.last = item_a_q.last_in;
  assign side_a.neg  = s_a[SB-1];
  assign side_a.mag  = s_a[SB-1] ? SB'(~s_a + 1'b1) : s_a;

  // taper
  logic             tp_vld;
  logic [Q30_W-1:0] tp_val;
  tside_t           tp_side;

  vts_taper #(
    .SIDE_W ($bits(tside_t))
  ) u_taper (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vld_a_q),
    .ctrl_i     (item_a_q.control_level),
    .side_i     (side_a),
    .exponent_i (taper_exp_q),
    .valid_o    (tp_vld),
    .taper_o    (tp_val),
    .side_o     (tp_side)
  );

  // drive scaling, tanh argument and its log2 scaling
  logic [DT_W-1:0]  dt_prod;
  logic [MP_W-1:0]  q0_sum, arg_prod;
  logic [WP_W-1:0]  w_prod, wd_prod;
  logic             vld_m1_q, vld_m2_q, vld_m3_q;
  logic [Q30_W-1:0] dt_m1_q;
  logic [SB-1:0]    q0_m1_q, q0_m2_q, mag_m1_q;
  logic             neg_m1_q, neg_m2_q, last_m1_q, last_m2_q;
  logic [ARG_W-1:0] arg_m2_q;
  logic [W_W-1:0]   w_m3_q, wd_m3_q;
  sside_t           ss_m3_q;
  logic             last_m3_q;

  assign dt_prod  = DT_W'(drive_q) * DT_W'(tp_val);
  assign q0_sum   = MP_W'(tp_val) * MP_W'(tp_side.mag) + MP_W'(ROUND_Q30);
  assign arg_prod = MP_W'(dt_m1_q) * MP_W'(mag_m1_q);
  assign w_prod   = WP_W'(arg_m2_q) * WP_W'(LOG2E_Q30);
  assign wd_prod  = (WP_W'(drive_q) << CFG_FRAC) * WP_W'(LOG2E_Q30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_m1_q <= 1'b0;
      vld_m2_q <= 1'b0;
      vld_m3_q <= 1'b0;
    end else begin
      vld_m1_q <= tp_vld;
      vld_m2_q <= vld_m1_q;
      vld_m3_q <= vld_m2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_m1_q    <= dt_prod[CFG_W +: Q30_W];
    q0_m1_q    <= q0_sum[Q30_FRAC +: SB];
    mag_m1_q   <= tp_side.mag;
    neg_m1_q   <= tp_side.neg;
    last_m1_q  <= tp_side.last;
    arg_m2_q   <= arg_prod[SB+1 +: ARG_W];
    q0_m2_q    <= q0_m1_q;
    neg_m2_q   <= neg_m1_q;
    last_m2_q  <= last_m1_q;
    w_m3_q     <= w_prod[LOG2E_SHIFT +: W_W];
    wd_m3_q    <= wd_prod[LOG2E_SHIFT +: W_W];
    ss_m3_q    <= '{neg: neg_m2_q, q0: q0_m2_q};
    last_m3_q  <= last_m2_q;
  end

  // exp2 lanes for the sample and for the drive normalization
  logic             zs_vld, zd_vld;
  logic [Q30_W-1:0] zs, zd;
  sside_t           zs_side;
  logic             zd_last;

  vts_exp2 #(
    .SIDE_W ($bits(sside_t))
  ) u_exp2_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_m3_q),
    .w_i     (w_m3_q),
    .side_i  (ss_m3_q),
    .valid_o (zs_vld),
    .res_o   (zs),
    .side_o  (zs_side)
  );

  vts_exp2 #(
    .SIDE_W (1)
  ) u_exp2_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_m3_q),
    .w_i     (wd_m3_q),
    .side_i  (last_m3_q),
    .valid_o (zd_vld),
    .res_o   (zd),
    .side_o  (zd_last)
  );

  // tanh = (1 - z) / (1 + z)
  logic                   ts_vld, td_vld;
  logic [TANH_Q_W-1:0]    ts, td;
  sside_t                 ts_side;
  logic                   td_last;

  vts_div #(
    .Q_W    (TANH_Q_W),
    .DEN_W  (TDEN_W),
    .SIDE_W ($bits(sside_t))
  ) u_div_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (zs_vld),
    .num_i   ({2'b00, ONE_Q30 - zs, Q30_FRAC'(0)}),
    .den_i   ({1'b0, ONE_Q30} + {1'b0, zs}),
    .side_i  (zs_side),
    .valid_o (ts_vld),
    .quo_o   (ts),
    .side_o  (ts_side)
  );

  vts_div #(
    .Q_W    (TANH_Q_W),
    .DEN_W  (TDEN_W),
    .SIDE_W (1)
  ) u_div_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (zd_vld),
    .num_i   ({2'b00, ONE_Q30 - zd, Q30_FRAC'(0)}),
    .den_i   ({1'b0, ONE_Q30} + {1'b0, zd}),
    .side_i  (zd_last),
    .valid_o (td_vld),
    .quo_o   (td),
    .side_o  (td_last)
  );

  // rounded numerator for the normalization
  logic              vld_f_q;
  logic [Q30_W-1:0]  td_fix, td_f_q;
  logic [NUMF_W-1:0] num_f_q;
  sside_t            ss_f_q;
  logic              last_f_q;
  fside_t            fs_in, fs_out;

  assign td_fix = (td == '0) ? Q30_W'(1) : td;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_f_q <= 1'b0;
    else         vld_f_q <= ts_vld & td_vld;
  end

  always_ff @(posedge clk_i) begin
    num_f_q  <= (NUMF_W'(ts) << (SB - 1)) + NUMF_W'(td_fix >> 1);
    td_f_q   <= td_fix;
    ss_f_q   <= ts_side;
    last_f_q <= td_last;
  end

  // a quotient too large for the divider saturates anyway
  assign fs_in.sat  = (num_f_q[QW +: Q30_W] >= td_f_q);
  assign fs_in.neg  = ss_f_q.neg;
  assign fs_in.q0   = ss_f_q.q0;
  assign fs_in.last = last_f_q;

  logic            q_vld;
  logic [QW-1:0]   q_div;

  vts_div #(
    .Q_W    (QW),
    .DEN_W  (Q30_W),
    .SIDE_W ($bits(fside_t))
  ) u_div_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_f_q),
    .num_i   (num_f_q),
    .den_i   (td_f_q),
    .side_i  (fs_in),
    .valid_o (q_vld),
    .quo_o   (q_div),
    .side_o  (fs_out)
  );

  // select, saturate, apply sign
  localparam logic [QW-1:0] LIM = QW'(1) << (SB - 1);
  logic [QW-1:0] q_sel, q_clip, q_neg;
  logic          strobe_q;
  out_item_t     result_q, result_d;

  always_comb begin
    priority if (drive_q == '0) begin
      q_sel = QW'(fs_out.q0);
    end else if (fs_out.sat) begin
      q_sel = '1;
    end else begin
      q_sel = q_div;
    end
    if (fs_out.neg) begin
      q_clip = (q_sel > LIM) ? LIM : q_sel;
    end else begin
      q_clip = (q_sel > LIM - 1'b1) ? LIM - 1'b1 : q_sel;
    end
    q_neg               = ~q_clip + 1'b1;
    result_d.sample_out = fs_out.neg ? q_neg[SB-1:0] : q_clip[SB-1:0];
    result_d.last_out   = fs_out.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) strobe_q <= 1'b0;
    else         strobe_q <= q_vld;
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = result_q;

  // checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching input transfer");

  a_exp_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zs_vld == zd_vld)
    else $error("exp2 lanes out of step");

  a_div_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ts_vld == td_vld)
    else $error("tanh divider lanes out of step");

endmodule
